// File: design/triangle_coverage_depth_top_assert.svh
// ----------------------------------------------------------------------------
// triangle_coverage_depth_top_assert.svh
// Assertion macros shared by the triangle coverage block.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_COVERAGE_DEPTH_TOP_ASSERT_SVH
`define TRIANGLE_COVERAGE_DEPTH_TOP_ASSERT_SVH

// expression must never hold outside reset
`define TCD_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define TCD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Types and constants of the triangle coverage and depth block.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    localparam int XY_W      = 16;
    localparam int Z_W       = 24;
    localparam int AREA_W    = 35;   // signed doubled area / edge value
    localparam int TOT_W     = 34;   // positive area magnitude
    localparam int WQ_W      = 23;   // weight quotient, Q1.22 up to 1.0
    localparam int WDIV_STEPS = 22;
    localparam int R_W       = 41;   // reciprocal depth, Q25.16
    localparam int RLO_W     = 21;
    localparam int RHI_W     = R_W - RLO_W;
    localparam int PL_W      = WQ_W + RLO_W;
    localparam int PH_W      = WQ_W + RHI_W;
    localparam int PROD_W    = 64;
    localparam int S_W       = 65;
    localparam int D_W       = 24;
    localparam int DDIV_STEPS = D_W;
    localparam int ADDR_W    = 5;
    localparam int RBIT_LAST = R_W - 1;

    localparam logic [R_W-1:0]  RECIP_RESET = R_W'(65536);
    localparam logic [D_W-1:0]  DEPTH_MAX   = {D_W{1'b1}};
    localparam logic [Z_W-1:0]  Z_RESET     = {Z_W{1'b1}};
    localparam logic [S_W-1:0]  SAT_LIMIT   = S_W'(1) << 38;

    // edge i runs from vertex EDGE_A[i] to vertex EDGE_B[i]
    localparam int EDGE_A [3] = '{1, 2, 0};
    localparam int EDGE_B [3] = '{2, 0, 1};

    typedef enum logic [2:0] {
        REG_V0_XY = 3'd0,
        REG_V1_XY = 3'd1,
        REG_V2_XY = 3'd2,
        REG_V0_Z  = 3'd3,
        REG_V1_Z  = 3'd4,
        REG_V2_Z  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CFG_IDLE,
        CFG_AREA_MUL,
        CFG_AREA_SUB,
        CFG_RECIP
    } cfg_state_t;

    typedef struct packed {
        logic [2:0][XY_W-1:0] vx;
        logic [2:0][XY_W-1:0] vy;
        logic [AREA_W-1:0]    area;
        logic [2:0][R_W-1:0]  recip;
        logic                 busy;
    } cfg_t;

    typedef struct packed {
        logic           degenerate;
        logic [D_W-1:0] depth;
        logic           covered;
    } result_t;

endpackage

`default_nettype wire

// File: design/tcd_cfg.sv
// ----------------------------------------------------------------------------
// tcd_cfg
// Register file, area and per-vertex reciprocal depth precompute.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output tcd_pkg::cfg_t                  cfg
);
    import tcd_pkg::*;

    logic [31:0]          vxy_reg   [3];
    logic [Z_W-1:0]       vz_reg    [3];
    logic [R_W-1:0]       recip_reg [3];
    logic [AREA_W-1:0]    area_reg;
    logic signed [33:0]   am1_reg, am2_reg;
    cfg_state_t           state_reg, state_next;
    logic [1:0]           lane_reg;
    logic [5:0]           bit_reg;
    logic [Z_W-1:0]       rem_reg;
    logic [R_W-2:0]       q_reg;

    logic                 wr;
    reg_idx_t             idx;
    logic                 known;
    logic [Z_W-1:0]       z;
    logic [Z_W:0]         r2;
    logic                 ge;
    logic signed [16:0]   dx2, dy2, dx1, dy1;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign known  = (paddr[4:2] <= 3'(REG_V2_Z));

    always_comb begin
        case (idx)
            REG_V0_XY: prdata = vxy_reg[0];
            REG_V1_XY: prdata = vxy_reg[1];
            REG_V2_XY: prdata = vxy_reg[2];
            REG_V0_Z:  prdata = 32'(vz_reg[0]);
            REG_V1_Z:  prdata = 32'(vz_reg[1]);
            REG_V2_Z:  prdata = 32'(vz_reg[2]);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CFG_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CFG_IDLE: begin
                if (wr && known) state_next = CFG_AREA_MUL;
            end
            CFG_AREA_MUL: state_next = CFG_AREA_SUB;
            CFG_AREA_SUB: state_next = CFG_RECIP;
            CFG_RECIP: begin
                if (bit_reg == 6'd0 && lane_reg == 2'd2) state_next = CFG_IDLE;
            end
            default: state_next = CFG_IDLE;
        endcase
    end

    // area = cross(v2 - v0, v1 - v0)
    assign dx2 = {vxy_reg[2][15], vxy_reg[2][15:0]}  - {vxy_reg[0][15], vxy_reg[0][15:0]};
    assign dy2 = {vxy_reg[2][31], vxy_reg[2][31:16]} - {vxy_reg[0][31], vxy_reg[0][31:16]};
    assign dx1 = {vxy_reg[1][15], vxy_reg[1][15:0]}  - {vxy_reg[0][15], vxy_reg[0][15:0]};
    assign dy1 = {vxy_reg[1][31], vxy_reg[1][31:16]} - {vxy_reg[0][31], vxy_reg[0][31:16]};

    // restoring divide of 2^40 by the lane depth, one bit per cycle
    assign z  = (vz_reg[lane_reg] == '0) ? Z_W'(1) : vz_reg[lane_reg];
    assign r2 = {rem_reg, (bit_reg == 6'(RBIT_LAST))};
    assign ge = (r2 >= {1'b0, z});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                vxy_reg[i]   <= '0;
                vz_reg[i]    <= Z_RESET;
                recip_reg[i] <= RECIP_RESET;
            end
            area_reg <= '0;
        end else begin
            if (wr && state_reg == CFG_IDLE) begin
                case (idx)
                    REG_V0_XY: vxy_reg[0] <= pwdata;
                    REG_V1_XY: vxy_reg[1] <= pwdata;
                    REG_V2_XY: vxy_reg[2] <= pwdata;
                    REG_V0_Z:  vz_reg[0]  <= pwdata[Z_W-1:0];
                    REG_V1_Z:  vz_reg[1]  <= pwdata[Z_W-1:0];
                    REG_V2_Z:  vz_reg[2]  <= pwdata[Z_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == CFG_AREA_SUB) begin
                area_reg <= AREA_W'(am1_reg) - AREA_W'(am2_reg);
            end
            if (state_reg == CFG_RECIP && bit_reg == 6'd0) begin
                recip_reg[lane_reg] <= {q_reg, ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        am1_reg <= dx2 * dy1;
        am2_reg <= dy2 * dx1;
        if (state_reg == CFG_AREA_SUB) begin
            lane_reg <= 2'd0;
            bit_reg  <= 6'(RBIT_LAST);
            rem_reg  <= '0;
            q_reg    <= '0;
        end else if (state_reg == CFG_RECIP) begin
            if (bit_reg == 6'd0) begin
                lane_reg <= lane_reg + 2'd1;
                bit_reg  <= 6'(RBIT_LAST);
                rem_reg  <= '0;
                q_reg    <= '0;
            end else begin
                rem_reg <= ge ? Z_W'(r2 - {1'b0, z}) : r2[Z_W-1:0];
                bit_reg <= bit_reg - 6'd1;
                q_reg   <= {q_reg[R_W-3:0], ge};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cfg.vx[i]    = vxy_reg[i][15:0];
            cfg.vy[i]    = vxy_reg[i][31:16];
            cfg.recip[i] = recip_reg[i];
        end
        cfg.area = area_reg;
        cfg.busy = (state_reg != CFG_IDLE);
    end

endmodule

`default_nettype wire

// File: design/triangle_coverage_depth_top.sv
// ----------------------------------------------------------------------------
// triangle_coverage_depth_top
// Per-pixel edge-function coverage test and perspective-correct depth.
// ----------------------------------------------------------------------------
//  channel  | dir | fields (low bit up)                         | handshake
//  ---------+-----+---------------------------------------------+-----------
//  s_       | in  | pixel_x[15:0], pixel_y[31:16]               | tvalid/tready
//  m_       | out | covered[0], depth[24:1], degenerate[25]     | tvalid/tready
//  APB      | in  | six registers at byte address 4*index       | psel/penable
//
//  One pixel request per clock while s_tready is high. The depth is set by
//  two pipelined long divisions, one bit per stage: 23 stages for the
//  weights and 24 for the final reciprocal. A register write recomputes
//  the area and three reciprocal depths on a shared serial divider;
//  s_tready stays low while that runs.
//  Synchronous active-low reset; no clearing pass. A full two-entry output
//  buffer freezes the whole pipeline, so a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "triangle_coverage_depth_top_assert.svh"

module triangle_coverage_depth_top (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [31:0]               s_tdata,   // pixel_x, pixel_y
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    output logic      [31:0]               m_tdata,   // covered, depth, degenerate
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tcd_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);
    import tcd_pkg::*;

    // stage map
    localparam int IDX_CLAMP = 3;
    localparam int IDX_WEND  = IDX_CLAMP + WDIV_STEPS;
    localparam int IDX_MULA  = IDX_WEND + 1;
    localparam int IDX_PROD  = IDX_MULA + 1;
    localparam int IDX_SUM   = IDX_PROD + 1;
    localparam int IDX_SAT   = IDX_SUM + 1;
    localparam int LAST      = IDX_SAT + DDIV_STEPS;
    localparam int NSTAGE    = LAST + 1;

    cfg_t cfg;

    tcd_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic en, in_fire;

    logic                 vld_reg [NSTAGE];
    logic                 cov_reg [IDX_CLAMP:LAST];
    logic                 deg_reg [IDX_CLAMP:LAST];
    logic                 sat_reg [IDX_SAT:LAST];

    logic signed [16:0]   pdx_reg [3], pdy_reg [3], bdx_reg [3], bdy_reg [3];
    logic signed [33:0]   m1_reg [3], m2_reg [3];
    logic signed [AREA_W-1:0] e_reg [3];
    logic [TOT_W-1:0]     wr_reg [0:WDIV_STEPS][3];
    logic [WQ_W-1:0]      wq_reg [0:WDIV_STEPS][3];
    logic [PL_W-1:0]      pl_reg [3];
    logic [PH_W-1:0]      ph_reg [3];
    logic [PROD_W-1:0]    prod_reg [3];
    logic [S_W-1:0]       sum_reg;
    logic [S_W-1:0]       dr_reg [0:DDIV_STEPS];
    logic [S_W-1:0]       ds_reg [0:DDIV_STEPS];
    logic [D_W-1:0]       dq_reg [0:DDIV_STEPS];

    result_t              out_reg, skid_reg, res_in;
    logic                 out_valid_reg, skid_valid_reg;

    logic signed [16:0]   px, py;
    logic [TOT_W-1:0]     total;
    logic                 area_pos;

    // pipeline moves whenever the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en && !cfg.busy;
    assign in_fire  = s_tvalid && s_tready;

    assign px       = {s_tdata[15], s_tdata[15:0]};
    assign py       = {s_tdata[31], s_tdata[31:16]};
    assign total    = cfg.area[TOT_W-1:0];
    assign area_pos = !cfg.area[AREA_W-1] && (cfg.area != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < NSTAGE; j++) vld_reg[j] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_fire;
            for (int j = 1; j < NSTAGE; j++) vld_reg[j] <= vld_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic ok;
        logic [TOT_W-1:0] ei;
        logic [TOT_W:0]   r2;
        logic             ge;
        logic [S_W:0]     d2;
        logic             dge;
        if (en) begin
            // stage 0: edge deltas
            for (int i = 0; i < 3; i++) begin
                pdx_reg[i] <= px - {cfg.vx[EDGE_A[i]][15], cfg.vx[EDGE_A[i]]};
                pdy_reg[i] <= py - {cfg.vy[EDGE_A[i]][15], cfg.vy[EDGE_A[i]]};
                bdx_reg[i] <= {cfg.vx[EDGE_B[i]][15], cfg.vx[EDGE_B[i]]}
                            - {cfg.vx[EDGE_A[i]][15], cfg.vx[EDGE_A[i]]};
                bdy_reg[i] <= {cfg.vy[EDGE_B[i]][15], cfg.vy[EDGE_B[i]]}
                            - {cfg.vy[EDGE_A[i]][15], cfg.vy[EDGE_A[i]]};
            end
            // stage 1: cross products
            for (int i = 0; i < 3; i++) begin
                m1_reg[i] <= pdx_reg[i] * bdy_reg[i];
                m2_reg[i] <= pdy_reg[i] * bdx_reg[i];
            end
            // stage 2: edge values
            for (int i = 0; i < 3; i++) begin
                e_reg[i] <= AREA_W'(m1_reg[i]) - AREA_W'(m2_reg[i]);
            end
            // stage 3: coverage, clamp, top weight bit
            ok = area_pos;
            for (int i = 0; i < 3; i++) ok = ok && !e_reg[i][AREA_W-1];
            cov_reg[IDX_CLAMP] <= ok;
            deg_reg[IDX_CLAMP] <= (cfg.area == '0);
            for (int i = 0; i < 3; i++) begin
                if (e_reg[i][AREA_W-1])                 ei = '0;
                else if (e_reg[i][TOT_W-1:0] > total)   ei = total;
                else                                    ei = e_reg[i][TOT_W-1:0];
                ge = (ei >= total);
                wr_reg[0][i] <= ge ? ei - total : ei;
                wq_reg[0][i] <= {{(WQ_W-1){1'b0}}, ge};
            end
            // weight division: e * 2^22 / area, one bit per stage
            for (int k = 1; k <= WDIV_STEPS; k++) begin
                cov_reg[IDX_CLAMP+k] <= cov_reg[IDX_CLAMP+k-1];
                deg_reg[IDX_CLAMP+k] <= deg_reg[IDX_CLAMP+k-1];
                for (int i = 0; i < 3; i++) begin
                    r2 = {wr_reg[k-1][i], 1'b0};
                    ge = (r2 >= {1'b0, total});
                    wr_reg[k][i] <= ge ? TOT_W'(r2 - {1'b0, total}) : r2[TOT_W-1:0];
                    wq_reg[k][i] <= {wq_reg[k-1][i][WQ_W-2:0], ge};
                end
            end
            // weight times reciprocal depth, split in two partial products
            cov_reg[IDX_MULA] <= cov_reg[IDX_WEND];
            deg_reg[IDX_MULA] <= deg_reg[IDX_WEND];
            for (int i = 0; i < 3; i++) begin
                pl_reg[i] <= PL_W'(wq_reg[WDIV_STEPS][i]) * PL_W'(cfg.recip[i][RLO_W-1:0]);
                ph_reg[i] <= PH_W'(wq_reg[WDIV_STEPS][i]) * PH_W'(cfg.recip[i][R_W-1:RLO_W]);
            end
            cov_reg[IDX_PROD] <= cov_reg[IDX_MULA];
            deg_reg[IDX_PROD] <= deg_reg[IDX_MULA];
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= {ph_reg[i], {RLO_W{1'b0}}} + PROD_W'(pl_reg[i]);
            end
            cov_reg[IDX_SUM] <= cov_reg[IDX_PROD];
            deg_reg[IDX_SUM] <= deg_reg[IDX_PROD];
            sum_reg <= S_W'(prod_reg[0]) + S_W'(prod_reg[1]) + S_W'(prod_reg[2]);
            // quotient 2^62 / S fits 24 bits only when S > 2^38
            cov_reg[IDX_SAT] <= cov_reg[IDX_SUM];
            deg_reg[IDX_SAT] <= deg_reg[IDX_SUM];
            sat_reg[IDX_SAT] <= (sum_reg <= SAT_LIMIT);
            dr_reg[0] <= SAT_LIMIT;
            ds_reg[0] <= sum_reg;
            dq_reg[0] <= '0;
            for (int k = 1; k <= DDIV_STEPS; k++) begin
                cov_reg[IDX_SAT+k] <= cov_reg[IDX_SAT+k-1];
                deg_reg[IDX_SAT+k] <= deg_reg[IDX_SAT+k-1];
                sat_reg[IDX_SAT+k] <= sat_reg[IDX_SAT+k-1];
                d2  = {dr_reg[k-1], 1'b0};
                dge = (d2 >= {1'b0, ds_reg[k-1]});
                dr_reg[k] <= dge ? S_W'(d2 - {1'b0, ds_reg[k-1]}) : d2[S_W-1:0];
                ds_reg[k] <= ds_reg[k-1];
                dq_reg[k] <= {dq_reg[k-1][D_W-2:0], dge};
            end
        end
    end

    always_comb begin
        res_in.covered    = cov_reg[LAST];
        res_in.degenerate = deg_reg[LAST];
        if (!cov_reg[LAST])     res_in.depth = '0;
        else if (sat_reg[LAST]) res_in.depth = DEPTH_MAX;
        else                    res_in.depth = dq_reg[DDIV_STEPS];
    end

    // output register plus skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (vld_reg[LAST]) begin
            if (!out_valid_reg || m_tready) begin
                out_reg       <= res_in;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_in;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(out_reg);

    `TCD_ASSERT_IMPLY(a_skid_needs_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `TCD_ASSERT_NEVER(a_no_accept_busy, s_tready && cfg.busy, "accepted during recompute")
    `TCD_ASSERT_IMPLY(a_miss_zero_depth, m_tvalid && !out_reg.covered, out_reg.depth == '0, "depth on miss")
    `TCD_ASSERT_NEVER(a_cov_vs_degen, m_tvalid && out_reg.covered && out_reg.degenerate, "degenerate hit")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for triangle_coverage_depth_top. Pixel requests go in on
// the s_ stream, and results are checked field by field against a local
// edge-function / depth predictor or a typed-in expectation. The triangle is
// reprogrammed over APB between phases. Both stream sides idle at random,
// and once the output side holds off for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import tcd_pkg::*;

    // ---------------- clock, reset, DUT ports ----------------
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // pixel_x[15:0], pixel_y[31:16]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // covered[0], depth[24:1], degenerate[25]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    always #5 aclk = ~aclk;

    triangle_coverage_depth_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // ---------------- shadow triangle state ----------------
    logic [31:0] vert_xy [3] = '{default: 32'h0};
    logic [23:0] vert_z  [3] = '{default: 24'hFF_FFFF};
    longint      twice_area = 0;

    result_t pending_results [$];
    int      err_count = 0;
    bit      gaps_on = 1'b1;   // random idling on both stream sides
    bit      hold_req = 1'b0;  // ask the receiver for a long hold-off

    localparam int DRAIN_CYCLES = 70;   // longer than the pipeline is deep
    localparam int HOLD_CYCLES  = 400;

    // doubled edge function cross(p - a, b - a)
    function automatic longint edge_val(longint px, longint py, logic [31:0] a,
                                        logic [31:0] b);
        longint ax, ay, bx, by;
        ax = longint'($signed(a[15:0]));
        ay = longint'($signed(a[31:16]));
        bx = longint'($signed(b[15:0]));
        by = longint'($signed(b[31:16]));
        return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
    endfunction

    function automatic void shadow_write(int idx, logic [31:0] value);
        if (idx < 3)
            vert_xy[idx] = value;
        else if (idx < 6)
            vert_z[idx - 3] = value[23:0];
        else
            return;     // unmapped index: ignored
        twice_area = edge_val(longint'($signed(vert_xy[2][15:0])),
                              longint'($signed(vert_xy[2][31:16])),
                              vert_xy[0], vert_xy[1]);
    endfunction

    function automatic result_t pixel_depth(logic [15:0] px, logic [15:0] py);
        result_t    res;
        longint     e [3];
        bit [63:0]  tot, ei, w, r, z, sum, q;
        longint     sx, sy;
        sx = longint'($signed(px));
        sy = longint'($signed(py));
        res = '0;
        e[0] = edge_val(sx, sy, vert_xy[1], vert_xy[2]);
        e[1] = edge_val(sx, sy, vert_xy[2], vert_xy[0]);
        e[2] = edge_val(sx, sy, vert_xy[0], vert_xy[1]);
        if (twice_area == 0) begin
            res.degenerate = 1'b1;
        end else if (e[0] >= 0 && e[1] >= 0 && e[2] >= 0 && twice_area > 0) begin
            res.covered = 1'b1;
            tot = 64'(twice_area);
            sum = '0;
            for (int i = 0; i < 3; i++) begin
                ei = 64'(e[i]);
                if (ei > tot)
                    ei = tot;
                w = (ei << 22) / tot;
                z = 64'(vert_z[i]);
                if (z == 0)
                    z = 1;
                r = (64'd1 << 40) / z;
                sum += w * r;
            end
            if (sum == 0) begin
                res.depth = DEPTH_MAX;
            end else begin
                q = (64'd1 << 62) / sum;
                res.depth = (q > 64'hFFFFFF) ? DEPTH_MAX : q[23:0];
            end
        end
        return res;
    endfunction

    // ---------------- APB register write ----------------
    task automatic reg_write(int idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);            // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_write(idx, value);
        // area/reciprocal recompute keeps s_tready low for a while
        repeat (2) @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait until every request has come back, then let the pipe drain
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // offer one pixel request; the expectation is queued on acceptance
    task automatic send_pixel(logic [15:0] px, logic [15:0] py, bit typed,
                              result_t typed_res);
        if (gaps_on && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(typed ? typed_res : pixel_depth(px, py));
    endtask

    // ---------------- receiver: random stalls and the long hold-off ----------------
    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < 28);
                @(posedge aclk);
            end
        end
    end

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                err_count++;
            end else begin
                result_t want;
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.covered) begin
                    $error("covered: expected %0d, got %0d", want.covered, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[24:1] !== want.depth) begin
                    $error("depth: expected %h, got %h", want.depth, m_tdata[24:1]);
                    err_count++;
                end
                if (m_tdata[25] !== want.degenerate) begin
                    $error("degenerate: expected %0d, got %0d",
                           want.degenerate, m_tdata[25]);
                    err_count++;
                end
            end
        end
    end

    // ---------------- directed table ----------------
    typedef enum logic {ROW_CFG, ROW_PIX} row_kind_t;
    typedef struct {
        row_kind_t   kind;
        int          idx;       // register index for ROW_CFG
        logic [31:0] value;     // register value, or {py, px} for ROW_PIX
        bit          typed;     // expected result typed in below
        result_t     res;
    } stim_row_t;

    // result_t packing: {degenerate, depth, covered}
    localparam result_t R_DEGEN = '{degenerate: 1'b1, depth: '0, covered: 1'b0};
    localparam result_t R_MISS  = '0;

    // triangle v0=(0,0) v1=(0,10.0) v2=(10.0,0) in Q12.4, positive area
    stim_row_t directed_rows [] = '{
        // reset state: zero area, every sample degenerate
        '{ROW_PIX, 0, 32'h0000_0000, 1, R_DEGEN},
        '{ROW_PIX, 0, 32'h7FFF_7FFF, 1, R_DEGEN},
        '{ROW_PIX, 0, 32'h8000_8000, 1, R_DEGEN},
        '{ROW_CFG, REG_V0_XY, 32'h0000_0000, 0, R_MISS},
        '{ROW_CFG, REG_V1_XY, 32'h00A0_0000, 0, R_MISS},
        '{ROW_CFG, REG_V2_XY, 32'h0000_00A0, 0, R_MISS},
        '{ROW_CFG, REG_V0_Z,  32'h0000_0001, 0, R_MISS},  // nearest depth
        '{ROW_CFG, REG_V1_Z,  32'h0000_0000, 0, R_MISS},  // zero depth acts as 1
        '{ROW_CFG, REG_V2_Z,  32'hFFFF_FFFF, 0, R_MISS},  // bits above 24 dropped
        '{ROW_CFG, 6,         32'hDEAD_BEEF, 0, R_MISS},  // unmapped, ignored
        '{ROW_CFG, 7,         32'h1234_5678, 0, R_MISS},
        '{ROW_PIX, 0, 32'h0000_0000, 0, R_MISS},          // on vertices
        '{ROW_PIX, 0, 32'h00A0_0000, 0, R_MISS},
        '{ROW_PIX, 0, 32'h0000_00A0, 0, R_MISS},
        '{ROW_PIX, 0, 32'h0028_0028, 0, R_MISS},          // interior
        '{ROW_PIX, 0, 32'h0050_0050, 0, R_MISS},          // on the long edge
        '{ROW_PIX, 0, 32'h0050_0051, 1, R_MISS},          // just past it
        '{ROW_PIX, 0, 32'hFFF0_FFF0, 1, R_MISS},
        '{ROW_PIX, 0, 32'h7FFF_7FFF, 1, R_MISS},
        '{ROW_PIX, 0, 32'h8000_8000, 1, R_MISS},
        '{ROW_CFG, REG_V0_Z,  32'h00FF_FFFF, 0, R_MISS},
        '{ROW_PIX, 0, 32'h0010_0030, 0, R_MISS},
        // reversed winding: negative area, nothing covered
        '{ROW_CFG, REG_V1_XY, 32'h0000_00A0, 0, R_MISS},
        '{ROW_CFG, REG_V2_XY, 32'h00A0_0000, 0, R_MISS},
        '{ROW_PIX, 0, 32'h0028_0028, 1, R_MISS}
    };

    // ---------------- random triangle setup ----------------
    int bb_x0, bb_x1, bb_y0, bb_y1;

    task automatic random_triangle(int shape);
        logic [31:0] v [3];
        int cx, cy, sz, x, y;
        cx = $urandom_range(60000) - 30000;
        cy = $urandom_range(60000) - 30000;
        sz = $urandom_range(1, 2000);
        for (int i = 0; i < 3; i++) begin
            if (shape == 1)
                v[i] = $urandom();              // anywhere, extremes included
            else
                v[i] = {16'(cy + int'($urandom_range(2 * sz)) - sz),
                        16'(cx + int'($urandom_range(2 * sz)) - sz)};
        end
        if (shape == 2)
            v[2] = v[$urandom_range(1)];        // collinear: zero area
        bb_x0 = 32767; bb_x1 = -32768; bb_y0 = 32767; bb_y1 = -32768;
        for (int i = 0; i < 3; i++) begin
            x = $signed(v[i][15:0]);
            y = $signed(v[i][31:16]);
            if (x < bb_x0) bb_x0 = x;
            if (x > bb_x1) bb_x1 = x;
            if (y < bb_y0) bb_y0 = y;
            if (y > bb_y1) bb_y1 = y;
            reg_write(REG_V0_XY + i, v[i]);
        end
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(5))
                0: reg_write(REG_V0_Z + i, 32'h1);
                1: reg_write(REG_V0_Z + i, 32'hFF_FFFF);
                default: reg_write(REG_V0_Z + i, $urandom());
            endcase
        end
    endtask

    // ---------------- main sequence ----------------
    initial begin
        logic [15:0] px, py;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < directed_rows.size(); i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_idle();
                reg_write(directed_rows[i].idx, directed_rows[i].value);
            end else begin
                send_pixel(directed_rows[i].value[15:0], directed_rows[i].value[31:16],
                           directed_rows[i].typed, directed_rows[i].res);
            end
        end

        // random phases: triangle shape varies, most pixels inside its box
        for (int ph = 0; ph < 8; ph++) begin
            wait_idle();
            gaps_on = (ph != 5);
            random_triangle(ph == 2 || ph == 6 ? 2 : (ph == 4 ? 1 : 0));
            if (ph == 3)
                hold_req = 1'b1;
            for (int n = 0; n < 142; n++) begin
                if ($urandom_range(99) < 70) begin
                    px = 16'(bb_x0 + int'($urandom_range(bb_x1 - bb_x0)));
                    py = 16'(bb_y0 + int'($urandom_range(bb_y1 - bb_y0)));
                end else begin
                    {py, px} = $urandom();
                end
                send_pixel(px, py, 1'b0, R_MISS);
            end
        end
        s_tvalid <= 1'b0;
        gaps_on = 1'b1;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    // ---------------- watchdog ----------------
    initial begin
        #50000000;
        $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+design
design/tcd_pkg.sv
design/tcd_cfg.sv
design/triangle_coverage_depth_top.sv
tb/testbench.sv
